// ===== design/itoa_pkg.sv =====
package itoa_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int QDEPTH = 2;
  localparam int BITS_PER_STEP = 4;

  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_NINE  = 7'h39;
  localparam logic [6:0] CHAR_MINUS = 7'h2d;

  // Control of one number handed from one part to the next.
  typedef struct packed {
    logic valid;
    logic neg;
  } num_ctl_t;

  typedef enum logic [1:0] {
    CV_IDLE,
    CV_RUN,
    CV_DONE
  } cv_state_t;

  // Decimal digits needed for the largest magnitude, 2^(bits-1).
  function automatic int num_digits(input int bits);
    longint unsigned p;
    int n;
    p = 64'd1 << (bits - 1);
    n = 1;
    while (p >= 64'd10) begin
      p = p / 10;
      n++;
    end
    return n;
  endfunction

endpackage

// ===== design/itoa_front.sv =====
module itoa_front #(
  parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [VALUE_BITS-1:0] in_value,
  output itoa_pkg::num_ctl_t           head,
  output logic        [VALUE_BITS-1:0] head_mag,
  input  logic                         pop
);
  import itoa_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  logic                  neg_q [QDEPTH];
  logic [VALUE_BITS-1:0] mag_q [QDEPTH];
  logic [PTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;

  logic                  push;
  logic                  do_pop;
  logic                  in_neg;
  logic [VALUE_BITS-1:0] in_mag;

  // The most negative value negates to itself, which read unsigned is its magnitude.
  assign in_neg   = in_value[VALUE_BITS-1];
  assign in_mag   = in_neg ? (~$unsigned(in_value) + 1'b1) : $unsigned(in_value);
  assign in_stall = (count_r == CNT_W'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign do_pop   = pop && (count_r != '0);

  assign head.valid = (count_r != '0);
  assign head.neg   = neg_q[rd_ptr_r];
  assign head_mag   = mag_q[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      neg_q[wr_ptr_r] <= in_neg;
      mag_q[wr_ptr_r] <= in_mag;
    end
  end

endmodule

// ===== design/itoa_cvt.sv =====
module itoa_cvt #(
  parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  itoa_pkg::num_ctl_t                              head,
  input  logic [VALUE_BITS-1:0]                           head_mag,
  output logic                                            pop,
  output itoa_pkg::num_ctl_t                              res,
  output logic [4*itoa_pkg::num_digits(VALUE_BITS)-1:0]   res_bcd,
  input  logic                                            res_ready
);
  import itoa_pkg::*;

  localparam int NDIG  = num_digits(VALUE_BITS);
  localparam int BCD_W = 4 * NDIG;
  localparam int STEPS = (VALUE_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int PAD_W = STEPS * BITS_PER_STEP;
  localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

  cv_state_t        state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PAD_W-1:0] sh_r, sh_nxt;
  logic [BCD_W-1:0] bcd_r, bcd_nxt;
  logic             neg_r, neg_nxt;

  logic [PAD_W-1:0] sh_step;
  logic [BCD_W-1:0] bcd_step;
  logic             load;
  logic             last_step;

  assign last_step = (cnt_r == CNT_W'(STEPS - 1));

  // Shift-add-3 conversion, several magnitude bits per cycle.
  always_comb begin
    logic [BCD_W-1:0] b;
    logic [PAD_W-1:0] s;
    b = bcd_r;
    s = sh_r;
    for (int k = 0; k < BITS_PER_STEP; k++) begin
      for (int d = 0; d < NDIG; d++) begin
        if (b[4*d +: 4] >= 4'd5) begin
          b[4*d +: 4] = b[4*d +: 4] + 4'd3;
        end
      end
      b = {b[BCD_W-2:0], s[PAD_W-1]};
      s = {s[PAD_W-2:0], 1'b0};
    end
    bcd_step = b;
    sh_step  = s;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CV_IDLE: if (head.valid) state_nxt = CV_RUN;
      CV_RUN:  if (last_step) state_nxt = CV_DONE;
      CV_DONE: if (res_ready) state_nxt = CV_IDLE;
      default: state_nxt = CV_IDLE;
    endcase
  end

  always_comb begin
    load      = 1'b0;
    pop       = 1'b0;
    res.valid = 1'b0;
    res.neg   = neg_r;
    unique case (state_r)
      CV_IDLE: begin
        load = head.valid;
        pop  = head.valid;
      end
      CV_RUN: begin
      end
      CV_DONE: begin
        res.valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign res_bcd = bcd_r;

  always_comb begin
    cnt_nxt = cnt_r;
    sh_nxt  = sh_r;
    bcd_nxt = bcd_r;
    neg_nxt = neg_r;
    if (load) begin
      cnt_nxt = '0;
      sh_nxt  = PAD_W'(head_mag);
      bcd_nxt = '0;
      neg_nxt = head.neg;
    end else if (state_r == CV_RUN) begin
      cnt_nxt = cnt_r + 1'b1;
      sh_nxt  = sh_step;
      bcd_nxt = bcd_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    sh_r  <= sh_nxt;
    bcd_r <= bcd_nxt;
    neg_r <= neg_nxt;
  end

endmodule

// ===== design/itoa_emit.sv =====
module itoa_emit #(
  parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  itoa_pkg::num_ctl_t                              res,
  input  logic [4*itoa_pkg::num_digits(VALUE_BITS)-1:0]   res_bcd,
  output logic                                            res_ready,
  output logic                                            out_valid,
  input  logic                                            out_stall,
  output logic [6:0]                                      out_char_code,
  output logic                                            out_is_last
);
  import itoa_pkg::*;

  localparam int NDIG  = num_digits(VALUE_BITS);
  localparam int BCD_W = 4 * NDIG;
  localparam int IDX_W = $clog2(NDIG);

  logic             busy_r, busy_nxt;
  logic             sgn_r, sgn_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [BCD_W-1:0] bcd_r, bcd_nxt;
  logic             ov_r, ov_nxt;
  logic [6:0]       char_r, char_nxt;
  logic             last_r, last_nxt;

  logic [IDX_W-1:0] lead;
  logic [3:0]       cur_dig;
  logic             adv;
  logic             take;

  // Position of the most significant nonzero digit; zero itself prints one digit.
  always_comb begin
    lead = '0;
    for (int d = 0; d < NDIG; d++) begin
      if (res_bcd[4*d +: 4] != 4'd0) begin
        lead = IDX_W'(d);
      end
    end
  end

  assign cur_dig   = bcd_r[{idx_r, 2'b00} +: 4];
  assign adv       = !ov_r || !out_stall;
  assign res_ready = !busy_r;
  assign take      = res.valid && !busy_r;

  always_comb begin
    busy_nxt = busy_r;
    sgn_nxt  = sgn_r;
    idx_nxt  = idx_r;
    bcd_nxt  = bcd_r;
    ov_nxt   = ov_r;
    char_nxt = char_r;
    last_nxt = last_r;
    if (take) begin
      busy_nxt = 1'b1;
      sgn_nxt  = res.neg;
      idx_nxt  = lead;
      bcd_nxt  = res_bcd;
    end else if (busy_r && adv) begin
      ov_nxt = 1'b1;
      if (sgn_r) begin
        char_nxt = CHAR_MINUS;
        last_nxt = 1'b0;
        sgn_nxt  = 1'b0;
      end else begin
        char_nxt = CHAR_ZERO + {3'b000, cur_dig};
        last_nxt = (idx_r == '0);
        if (idx_r == '0) begin
          busy_nxt = 1'b0;
        end else begin
          idx_nxt = idx_r - 1'b1;
        end
      end
    end
    if (!(busy_r && adv) && adv) begin
      ov_nxt = 1'b0;
    end
  end

  assign out_valid     = ov_r;
  assign out_char_code = char_r;
  assign out_is_last   = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sgn_r  <= sgn_nxt;
    idx_r  <= idx_nxt;
    bcd_r  <= bcd_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

endmodule

// ===== design/int32_to_decimal_ascii_core.sv =====
// An accepted value is registered in the input queue, converted by the shift-add-3
// converter, taken by the output stage and registered onto the output; after a number's
// first character, one character per cycle follows when not stalled. The rate of numbers
// is set by the four-bit-per-cycle shift-add-3 converter and the one-character-per-cycle
// output register. Conversion overlaps output of the previous number. Reset: synchronous,
// active low; it empties the input queue, idles the converter and clears out_valid.
module int32_to_decimal_ascii_core #(
  parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [VALUE_BITS-1:0] in_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [6:0]                   out_char_code,
  output logic                         out_is_last
);
  import itoa_pkg::*;

  localparam int BCD_W = 4 * num_digits(VALUE_BITS);

  num_ctl_t              head;
  logic [VALUE_BITS-1:0] head_mag;
  logic                  pop;
  num_ctl_t              res;
  logic [BCD_W-1:0]      res_bcd;
  logic                  res_ready;

  itoa_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_value (in_value),
    .head     (head),
    .head_mag (head_mag),
    .pop      (pop)
  );

  itoa_cvt #(.VALUE_BITS(VALUE_BITS)) u_cvt (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .head_mag  (head_mag),
    .pop       (pop),
    .res       (res),
    .res_bcd   (res_bcd),
    .res_ready (res_ready)
  );

  itoa_emit #(.VALUE_BITS(VALUE_BITS)) u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .res           (res),
    .res_bcd       (res_bcd),
    .res_ready     (res_ready),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char_code (out_char_code),
    .out_is_last   (out_is_last)
  );

  // Every character is a minus sign or a decimal digit.
  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_char_code == CHAR_MINUS ||
                   (out_char_code >= CHAR_ZERO && out_char_code <= CHAR_NINE)))
    else $error("output character is neither a minus sign nor a digit");

  // A run never ends on its sign.
  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_char_code == CHAR_MINUS) |-> !out_is_last)
    else $error("minus sign flagged as last character");

  // The queue only hands a number to the converter when it holds one.
  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head.valid)
    else $error("converter popped an empty queue");

  // Reset leaves no transaction on the output.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

// ===== bench/tb_int32_to_decimal_ascii_core.sv =====
`timescale 1ns / 100ps

module tb_int32_to_decimal_ascii_core;

  import itoa_pkg::*;

  localparam int VBITS = VALUE_BITS_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 500;

  typedef struct packed {
    logic [6:0] code;
    logic       last;
  } text_char_t;

  class decimal_text_scoreboard;
    text_char_t pending_chars[$];
    int         mismatches = 0;

    // Queues the characters one accepted value should produce.
    function void expect_text(logic [VBITS-1:0] value);
      logic [VBITS-1:0] mag;
      logic [3:0]       digits[$];
      text_char_t       ch;
      mag = value[VBITS-1] ? -value : value;
      do begin
        digits.push_front(4'(mag % 10));
        mag = mag / 10;
      end while (mag != 0);
      if (value[VBITS-1]) begin
        ch.code = CHAR_MINUS;
        ch.last = 1'b0;
        pending_chars.push_back(ch);
      end
      foreach (digits[i]) begin
        ch.code = CHAR_ZERO + 7'(digits[i]);
        ch.last = (i == digits.size() - 1);
        pending_chars.push_back(ch);
      end
    endfunction

    function void compare_char(logic [6:0] code, logic last);
      text_char_t want;
      if (pending_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected character: code %h last %b", code, last);
        return;
      end
      want = pending_chars.pop_front();
      if (want.code !== code || want.last !== last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("character mismatch: expected code %h last %b, got code %h last %b",
                   want.code, want.last, code, last);
      end
    endfunction

    function int pending();
      return pending_chars.size();
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [VBITS-1:0] in_value = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [6:0]              out_char_code;
  logic                    out_is_last;

  decimal_text_scoreboard sb = new;
  bit jitter_on = 1'b1;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int cycle_count = 0;

  logic [VBITS-1:0] corner_values [22] = '{
    32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd99, 32'sd100, -32'sd100,
    32'sd2147483647, 32'h80000000, 32'h80000001, 32'sd1000000000, 32'sd999999999,
    -32'sd999999999, 32'sd1999999999, 32'sd123456789, -32'sd123456789, 32'sd7,
    -32'sd9, 32'sd1000000001, -32'sd1000000000
  };

  int32_to_decimal_ascii_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char_code (out_char_code),
    .out_is_last   (out_is_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("int32_to_decimal_ascii_core regression: fail");
      $finish;
    end
  end

  // Result side: check each accepted transaction, then pick the next stall.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.compare_char(out_char_code, out_is_last);
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= jitter_on && ($urandom_range(99) < 33);
    end
  end

  function automatic logic [VBITS-1:0] random_value();
    longint unsigned span;
    longint unsigned mag;
    int pick;
    pick = $urandom_range(9);
    span = 1;
    if (pick < 4)
      return $urandom();
    if (pick < 8) begin
      // Uniform digit count keeps short numbers as common as long ones.
      repeat ($urandom_range(1, 10)) span = span * 10;
      mag = {$urandom(), $urandom()} % span;
    end else if (pick == 8) begin
      return corner_values[$urandom_range(9, 11)];
    end else begin
      repeat ($urandom_range(0, 9)) span = span * 10;
      mag = span + $urandom_range(2) - 1;
    end
    return $urandom_range(1) ? VBITS'(-mag) : VBITS'(mag);
  endfunction

  task automatic send_value(input logic [VBITS-1:0] value);
    while (jitter_on && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= value;
    do @(posedge clk); while (in_stall);
    sb.expect_text(value);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (corner_values[i])
      send_value(corner_values[i]);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 150)
        jitter_on = 1'b0;
      if (i == 300) begin
        // Long output stall while items keep coming, so the input backs up.
        jitter_on = 1'b1;
        hold_req = 1'b1;
      end
      send_value(random_value());
    end
    in_valid <= 1'b0;
    while (sb.pending() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("int32_to_decimal_ascii_core regression: pass");
    else
      $display("int32_to_decimal_ascii_core regression: fail");
    $finish;
  end

endmodule
